// File: rtl/emmt_pkg.sv
// ----------------------------------------------------------------------------
// emmt_pkg
// Shared types and constants for the event mask merge table.
// ----------------------------------------------------------------------------
package emmt_pkg;

    localparam int unsigned KINDS      = 3;
    localparam int unsigned MASK_W     = 64;
    localparam int unsigned HOST_W     = 4;

    localparam logic [7:0]  IND_COMMAND      = 8'h01;
    localparam logic [15:0] OP_EVENT_MASK    = 16'h0c01;
    localparam logic [15:0] OP_EVENT_MASK_P2 = 16'h0c63;
    localparam logic [15:0] OP_LE_EVENT_MASK = 16'h2001;
    localparam logic [7:0]  MASK_PARAM_LEN   = 8'd8;
    localparam logic [8:0]  MASK_CMD_LEN     = 9'd12;
    localparam logic [8:0]  MIN_CMD_LEN      = 9'd4;

    typedef enum logic [1:0] {
        ST_INVALID   = 2'd0,
        ST_PASS      = 2'd1,
        ST_REWRITTEN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_EVT = 2'd0,
        KIND_P2  = 2'd1,
        KIND_LE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                has_result;
        logic                write_en;
        logic                clear_en;
        t_kind               kind;
        logic [HOST_W-1:0]   host;
        t_status             status;
    } t_decode;

endpackage

// File: rtl/emmt_decode.sv
// ----------------------------------------------------------------------------
// emmt_decode
// Request checks: host range, lengths, indicator and opcode to mask kind.
// ----------------------------------------------------------------------------
module emmt_decode #(
    parameter int unsigned HOSTS = 2
) (
    input  logic                        i_func,
    input  logic [emmt_pkg::HOST_W-1:0] i_host,
    input  logic [7:0]                  i_packet_indicator,
    input  logic [15:0]                 i_opcode,
    input  logic [7:0]                  i_parameter_length,
    input  logic [8:0]                  i_packet_length,
    output emmt_pkg::t_decode           o_dec
);
    import emmt_pkg::*;

    localparam logic [HOST_W-1:0] HOST_LIMIT = HOST_W'(HOSTS);

    logic  host_ok;
    logic  head_ok;
    logic  is_mask_op;
    logic  len_ok;
    t_kind kind;

    always_comb begin
        host_ok = (i_host < HOST_LIMIT);
        head_ok = host_ok && (i_packet_length >= MIN_CMD_LEN)
                  && (i_packet_indicator == IND_COMMAND);
        len_ok  = (i_packet_length == MASK_CMD_LEN)
                  && (i_parameter_length == MASK_PARAM_LEN);
        is_mask_op = 1'b1;
        case (i_opcode)
            OP_EVENT_MASK:    kind = KIND_EVT;
            OP_EVENT_MASK_P2: kind = KIND_P2;
            OP_LE_EVENT_MASK: kind = KIND_LE;
            default: begin
                kind       = KIND_EVT;
                is_mask_op = 1'b0;
            end
        endcase

        o_dec.host       = i_host;
        o_dec.kind       = kind;
        o_dec.has_result = !i_func;
        o_dec.clear_en   = i_func && host_ok;
        o_dec.write_en   = !i_func && head_ok && is_mask_op && len_ok;
        if (!head_ok) begin
            o_dec.status = ST_INVALID;
        end else if (!is_mask_op) begin
            o_dec.status = ST_PASS;
        end else if (!len_ok) begin
            o_dec.status = ST_INVALID;
        end else begin
            o_dec.status = ST_REWRITTEN;
        end
    end

endmodule

// File: rtl/emmt_store.sv
// ----------------------------------------------------------------------------
// emmt_store
// Per-host, per-kind mask registers with present flags and the merged OR.
// ----------------------------------------------------------------------------
module emmt_store #(
    parameter int unsigned HOSTS = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  emmt_pkg::t_decode           i_dec,
    input  logic [emmt_pkg::MASK_W-1:0] i_mask_bits,
    output logic [emmt_pkg::MASK_W-1:0] o_merged
);
    import emmt_pkg::*;

    logic [MASK_W-1:0] r_mask    [KINDS][HOSTS];
    logic              r_present [KINDS][HOSTS];
    logic [MASK_W-1:0] n_mask    [KINDS][HOSTS];
    logic              n_present [KINDS][HOSTS];
    logic              sel_host  [HOSTS];

    always_comb begin
        for (int h = 0; h < HOSTS; h++) begin
            sel_host[h] = (i_dec.host == HOST_W'(h));
        end
        for (int k = 0; k < KINDS; k++) begin
            for (int h = 0; h < HOSTS; h++) begin
                n_mask[k][h]    = r_mask[k][h];
                n_present[k][h] = r_present[k][h];
                if (i_commit && sel_host[h]) begin
                    if (i_dec.clear_en) begin
                        n_mask[k][h]    = '0;
                        n_present[k][h] = 1'b0;
                    end else if (i_dec.write_en && (i_dec.kind == t_kind'(k))) begin
                        n_mask[k][h]    = i_mask_bits;
                        n_present[k][h] = 1'b1;
                    end
                end
            end
        end
        o_merged = '0;
        for (int k = 0; k < KINDS; k++) begin
            if (i_dec.kind == t_kind'(k)) begin
                for (int h = 0; h < HOSTS; h++) begin
                    if (sel_host[h]) begin
                        o_merged = o_merged | i_mask_bits;
                    end else if (r_present[k][h]) begin
                        o_merged = o_merged | r_mask[k][h];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KINDS; k++) begin
            for (int h = 0; h < HOSTS; h++) begin
                if (!i_rst_n) begin
                    r_mask[k][h]    <= '0;
                    r_present[k][h] <= 1'b0;
                end else begin
                    r_mask[k][h]    <= n_mask[k][h];
                    r_present[k][h] <= n_present[k][h];
                end
            end
        end
    end

endmodule

// File: rtl/event_mask_merge_table_top.sv
// ----------------------------------------------------------------------------
// event_mask_merge_table_top
// Merges per-host event masks into one controller mask per mask kind.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  in       | i_in_valid / o_in_stall    | func, host, indicator, opcode,
//           |                            | lengths, mask bits
//  out      | o_out_valid / i_out_stall  | status, merged_mask
//
//  One request a cycle unless a stalled result holds a command. Stages: input
//  register, checks and merge, result register. Remove requests make no result.
//  Reset clears the mask store, present flags and both valid stages.
//  A stalled result holds the input stage only if it carries a command.
// ----------------------------------------------------------------------------
module event_mask_merge_table_top #(
    parameter int unsigned HOSTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [3:0]  i_host,
    input  logic [7:0]  i_packet_indicator,
    input  logic [15:0] i_opcode,
    input  logic [7:0]  i_parameter_length,
    input  logic [8:0]  i_packet_length,
    input  logic [63:0] i_mask_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_merged_mask
);
    import emmt_pkg::*;

    logic              r_s1_valid;
    logic              r_s1_func;
    logic [HOST_W-1:0] r_s1_host;
    logic [7:0]        r_s1_ind;
    logic [15:0]       r_s1_op;
    logic [7:0]        r_s1_plen;
    logic [8:0]        r_s1_tlen;
    logic [MASK_W-1:0] r_s1_bits;

    logic              r_out_valid;
    t_status           r_status;
    logic [MASK_W-1:0] r_merged;

    t_decode           dec;
    logic [MASK_W-1:0] merged;
    logic              s1_adv;
    logic              in_acc;

    emmt_decode #(.HOSTS(HOSTS)) u_decode (
        .i_func             (r_s1_func),
        .i_host             (r_s1_host),
        .i_packet_indicator (r_s1_ind),
        .i_opcode           (r_s1_op),
        .i_parameter_length (r_s1_plen),
        .i_packet_length    (r_s1_tlen),
        .o_dec              (dec)
    );

    emmt_store #(.HOSTS(HOSTS)) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s1_adv),
        .i_dec       (dec),
        .i_mask_bits (r_s1_bits),
        .o_merged    (merged)
    );

    assign s1_adv     = r_s1_valid && (!dec.has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1_func <= i_func;
            r_s1_host <= i_host;
            r_s1_ind  <= i_packet_indicator;
            r_s1_op   <= i_opcode;
            r_s1_plen <= i_parameter_length;
            r_s1_tlen <= i_packet_length;
            r_s1_bits <= i_mask_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && dec.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && dec.has_result) begin
            r_status <= dec.status;
            r_merged <= (dec.status == ST_REWRITTEN) ? merged : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_merged_mask = r_merged;

`ifndef SYNTH
    a_zero_unless_rewritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_REWRITTEN) |-> o_merged_mask == '0)
        else $error("merged mask not zero on a non-rewritten result");

    a_own_mask_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && dec.write_en |=>
        o_out_valid && ((o_merged_mask & $past(r_s1_bits)) == $past(r_s1_bits)))
        else $error("stored mask missing from merged result");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && dec.has_result && r_out_valid)
        else $error("input stalled without a blocked command");

    a_remove_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && !dec.has_result && !r_out_valid |=> !o_out_valid)
        else $error("remove request produced a result");
`endif

endmodule

// File: verif/emmt_tb_pkg.sv
// ----------------------------------------------------------------------------
// emmt_tb_pkg
// Request type and merged mask tracker for the event mask merge table bench.
// The tracker keeps its own copy of the per-host mask store, works out the
// answer to every accepted command and checks results against it in order.
// ----------------------------------------------------------------------------
package emmt_tb_pkg;

    import emmt_pkg::*;

    typedef enum logic {
        FN_COMMAND = 1'b0,
        FN_REMOVE  = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [3:0]  host;
        logic [7:0]  indicator;
        logic [15:0] opcode;
        logic [7:0]  param_len;
        logic [8:0]  packet_len;
        logic [63:0] mask_bits;
    } t_mask_request;

    typedef struct packed {
        t_status     status;
        logic [63:0] merged;
    } t_mask_answer;

    class merged_mask_tracker #(int unsigned HOSTS_N = 2);

        logic [63:0]  stored_mask [KINDS][HOSTS_N];
        logic         mask_held   [KINDS][HOSTS_N];
        t_mask_answer answers_due [$];
        int unsigned  mismatches;

        function new();
            for (int k = 0; k < KINDS; k++) begin
                for (int h = 0; h < HOSTS_N; h++) begin
                    stored_mask[k][h] = '0;
                    mask_held[k][h]   = 1'b0;
                end
            end
            mismatches = 0;
        endfunction

        function void note_request(t_mask_request r);
            t_mask_answer ans;
            t_kind        kind;
            logic         is_mask_op;
            if (r.func == FN_REMOVE) begin
                if (r.host < HOSTS_N) begin
                    for (int k = 0; k < KINDS; k++) begin
                        stored_mask[k][r.host] = '0;
                        mask_held[k][r.host]   = 1'b0;
                    end
                end
                return;
            end
            ans.merged = '0;
            is_mask_op = 1'b1;
            kind       = KIND_EVT;
            case (r.opcode)
                OP_EVENT_MASK:    kind = KIND_EVT;
                OP_EVENT_MASK_P2: kind = KIND_P2;
                OP_LE_EVENT_MASK: kind = KIND_LE;
                default:          is_mask_op = 1'b0;
            endcase
            if (r.host >= HOSTS_N || r.packet_len < MIN_CMD_LEN
                    || r.indicator != IND_COMMAND) begin
                ans.status = ST_INVALID;
            end else if (!is_mask_op) begin
                ans.status = ST_PASS;
            end else if (r.packet_len != MASK_CMD_LEN || r.param_len != MASK_PARAM_LEN) begin
                ans.status = ST_INVALID;
            end else begin
                stored_mask[kind][r.host] = r.mask_bits;
                mask_held[kind][r.host]   = 1'b1;
                for (int h = 0; h < HOSTS_N; h++) begin
                    if (mask_held[kind][h])
                        ans.merged |= stored_mask[kind][h];
                end
                ans.status = ST_REWRITTEN;
            end
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %0s", what);
            mismatches++;
        endtask

        task check_result(logic [1:0] status, logic [63:0] merged);
            t_mask_answer ans;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d mask %h",
                                          status, merged));
                return;
            end
            ans = answers_due.pop_front();
            if (status !== ans.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, ans.status));
            if (merged !== ans.merged)
                report_mismatch($sformatf("merged mask %h, expected %h", merged, ans.merged));
        endtask

    endclass

endpackage

// File: verif/tb_event_mask_merge_table_top.sv
// ----------------------------------------------------------------------------
// tb_event_mask_merge_table_top
// Bench for the event mask merge table.
// Directed requests cover field extremes, every mask kind, removes and each
// rejection path; random requests, mostly well formed mask commands from a
// few hosts, follow. Both channels idle at random in the first two of three
// phases. Results are checked in order against the merged mask tracker.
// ----------------------------------------------------------------------------
module tb_event_mask_merge_table_top;

    timeunit 1ns;
    timeprecision 1ps;

    import emmt_pkg::*;
    import emmt_tb_pkg::*;

    localparam int unsigned NUM_HOSTS   = 2;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_func;
    logic [3:0]  i_host;
    logic [7:0]  i_packet_indicator;
    logic [15:0] i_opcode;
    logic [7:0]  i_parameter_length;
    logic [8:0]  i_packet_length;
    logic [63:0] i_mask_bits;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [63:0] o_merged_mask;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycles;

    merged_mask_tracker #(NUM_HOSTS) tracker;

    event_mask_merge_table_top #(
        .HOSTS(NUM_HOSTS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_host             (i_host),
        .i_packet_indicator (i_packet_indicator),
        .i_opcode           (i_opcode),
        .i_parameter_length (i_parameter_length),
        .i_packet_length    (i_packet_length),
        .i_mask_bits        (i_mask_bits),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_merged_mask      (o_merged_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_status, o_merged_mask);
    end

    function automatic t_mask_request make_command(logic [3:0] host, logic [7:0] ind,
                                                   logic [15:0] op, logic [7:0] plen,
                                                   logic [8:0] tlen, logic [63:0] bits);
        t_mask_request r;
        r.func       = FN_COMMAND;
        r.host       = host;
        r.indicator  = ind;
        r.opcode     = op;
        r.param_len  = plen;
        r.packet_len = tlen;
        r.mask_bits  = bits;
        return r;
    endfunction

    function automatic t_mask_request make_remove(logic [3:0] host);
        t_mask_request r;
        r      = make_command(host, IND_COMMAND, OP_EVENT_MASK, MASK_PARAM_LEN,
                              MASK_CMD_LEN, '0);
        r.func = FN_REMOVE;
        return r;
    endfunction

    function automatic t_mask_request random_request();
        t_mask_request r;
        int unsigned   pick;
        r.func      = ($urandom_range(99) < 12) ? FN_REMOVE : FN_COMMAND;
        r.host      = ($urandom_range(9) == 0) ? 4'($urandom)
                                               : 4'($urandom_range(NUM_HOSTS - 1));
        r.indicator = ($urandom_range(15) == 0) ? 8'($urandom) : IND_COMMAND;
        pick = $urandom_range(9);
        r.opcode    = (pick < 3) ? OP_EVENT_MASK :
                      (pick < 6) ? OP_EVENT_MASK_P2 :
                      (pick < 8) ? OP_LE_EVENT_MASK : 16'($urandom);
        r.param_len = ($urandom_range(11) == 0) ? 8'($urandom) : MASK_PARAM_LEN;
        pick = $urandom_range(19);
        r.packet_len = (pick == 0) ? 9'($urandom) :
                       (pick == 1) ? 9'($urandom_range(3)) :
                       (pick == 2) ? 9'd511 : MASK_CMD_LEN;
        case ($urandom_range(3))
            0:       r.mask_bits = {$urandom, $urandom};
            1:       r.mask_bits = 64'd1 << $urandom_range(63);
            2:       r.mask_bits = $urandom_range(1) ? '1 : '0;
            default: r.mask_bits = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(t_mask_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_func             <= r.func;
        i_host             <= r.host;
        i_packet_indicator <= r.indicator;
        i_opcode           <= r.opcode;
        i_parameter_length <= r.param_len;
        i_packet_length    <= r.packet_len;
        i_mask_bits        <= r.mask_bits;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    initial begin
        tracker            = new();
        cycles             = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_func             = 1'b0;
        i_host             = '0;
        i_packet_indicator = '0;
        i_opcode           = '0;
        i_parameter_length = '0;
        i_packet_length    = '0;
        i_mask_bits        = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 11 : 0;
            if (phase == 0) begin
                send_request(make_command(4'd0, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'h0000_0000_0000_00ff));
                send_request(make_command(4'd1, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'hff00_0000_0000_0000));
                send_request(make_command(4'd0, IND_COMMAND, OP_EVENT_MASK_P2,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, '1));
                send_request(make_command(4'd1, IND_COMMAND, OP_LE_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, '0));
                send_request(make_command(4'd0, IND_COMMAND, OP_LE_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'h8000_0000_0000_0001));
                // host out of range on a command
                send_request(make_command(4'hf, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, '1));
                send_request(make_command(4'(NUM_HOSTS), IND_COMMAND, OP_LE_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, '1));
                // short packet wins over opcode
                send_request(make_command(4'd0, IND_COMMAND, 16'hffff, 8'hff, 9'd3, '1));
                send_request(make_command(4'd1, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, 9'd0, '1));
                send_request(make_command(4'd0, 8'h00, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, '1));
                send_request(make_command(4'd1, 8'hff, 16'h1234, 8'd0, 9'd4, '1));
                // other opcodes pass with any length
                send_request(make_command(4'd0, IND_COMMAND, 16'hffff, 8'hff, 9'd511, '1));
                send_request(make_command(4'd1, IND_COMMAND, 16'h0000, 8'd0, 9'd4, '0));
                // mask opcodes with wrong lengths store nothing
                send_request(make_command(4'd0, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, 9'd13, '1));
                send_request(make_command(4'd1, IND_COMMAND, OP_EVENT_MASK_P2,
                                          8'd7, MASK_CMD_LEN, '1));
                send_request(make_command(4'd0, IND_COMMAND, OP_LE_EVENT_MASK,
                                          MASK_PARAM_LEN, 9'd511, '1));
                send_request(make_remove(4'd1));
                send_request(make_remove(4'hf));
                send_request(make_command(4'd0, IND_COMMAND, OP_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'h0000_ffff_0000_0000));
                send_request(make_command(4'd1, IND_COMMAND, OP_EVENT_MASK_P2,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'h5555_5555_5555_5555));
                send_request(make_remove(4'd0));
                send_request(make_command(4'd1, IND_COMMAND, OP_LE_EVENT_MASK,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'haaaa_aaaa_aaaa_aaaa));
                send_request(make_command(4'd0, IND_COMMAND, OP_EVENT_MASK_P2,
                                          MASK_PARAM_LEN, MASK_CMD_LEN, 64'h0123_4567_89ab_cdef));
            end
            repeat (150) send_request(random_request());
        end
        i_in_valid <= 1'b0;

        while (tracker.answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.answers_due.size() != 0)
            tracker.report_mismatch("results still outstanding at end of run");
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
